>>> rtl/longest_prefix_route_match_macros.svh
// Assertion macros for the route match engine
`ifndef LONGEST_PREFIX_ROUTE_MATCH_MACROS_SVH
`define LONGEST_PREFIX_ROUTE_MATCH_MACROS_SVH
`ifndef SYNTHESIS
// Check that prop holds at every rising edge of clk outside reset.
`define LPM_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Check that cons holds whenever ante holds.
`define LPM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`else
`define LPM_ASSERT(label, clk, rst_n, prop, msg)
`define LPM_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif
`endif

>>> rtl/lpm_pkg.sv
// Types, opcodes and prefix-length helper for the route match engine
`timescale 1ns / 1ps
`default_nettype none
package lpm_pkg;

	localparam logic OP_WRITE  = 1'b0;
	localparam logic OP_LOOKUP = 1'b1;

	typedef struct packed {
		logic        op;
		logic [3:0]  entry_index;
		logic [31:0] entry_dest;
		logic [31:0] entry_mask;
		logic        entry_valid;
		logic [31:0] lookup_addr;
	} lpm_req_t;

	typedef struct packed {
		logic       found;
		logic [3:0] match_index;
		logic [5:0] match_prefix_len;
	} lpm_rsp_t;

	// Leading ones of the mask, found as leading zeros of its inverse by halving.
	function automatic logic [5:0] lead_ones(input logic [31:0] mask);
		logic [31:0] v;
		logic [5:0]  n;
		v = ~mask;
		n = '0;
		if (v == '0) begin
			n = 6'd32;
		end else begin
			if (v[31:16] == '0) begin n = n + 6'd16; v = v << 16; end
			if (v[31:24] == '0) begin n = n + 6'd8;  v = v << 8;  end
			if (v[31:28] == '0) begin n = n + 6'd4;  v = v << 4;  end
			if (v[31:30] == '0) begin n = n + 6'd2;  v = v << 2;  end
			if (v[31] == 1'b0) begin n = n + 6'd1; end
		end
		return n;
	endfunction

endpackage
`default_nettype wire

>>> rtl/longest_prefix_route_match.sv
// Route table with longest prefix match, scanned by one compare unit
//
//  channel   signals              handshake
//  --------  -------------------  -----------------------------------------
//  request   req                  word taken on start high while busy low
//  result    rsp                  word valid for the one cycle done is high
//
// A write below TABLE_DEPTH takes effect at the accepting edge; any write leaves busy low.
// A lookup holds busy while it scans all min(TABLE_DEPTH,16) entries and drains:
// one table entry is read per cycle through the single compare stage.
// The result strobes at the same edge at which busy falls; it cannot stall.
// Reset clears the valid bits and the sequencer; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "longest_prefix_route_match_macros.svh"
module longest_prefix_route_match #(
	parameter int TABLE_DEPTH = 16
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	output logic                  busy,
	input  wire lpm_pkg::lpm_req_t req,
	output logic                  done,
	output lpm_pkg::lpm_rsp_t     rsp
);
	import lpm_pkg::*;

	// Only slots reachable by a 4-bit index can ever hold a route.
	localparam int VALID_DEPTH = (TABLE_DEPTH < 16) ? TABLE_DEPTH : 16;
	localparam int IDX_W       = $clog2(VALID_DEPTH);

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_DRAIN = 3'b100
	} state_t;

	state_t state_q;

	logic [31:0]      dest_mem [VALID_DEPTH];
	logic [31:0]      mask_mem [VALID_DEPTH];
	logic             valid_q  [VALID_DEPTH];

	logic [IDX_W-1:0] ptr_q;
	logic [31:0]      addr_q;

	logic             v_s1, last_s1, vbit_s1;
	logic [IDX_W-1:0] idx_s1;
	logic [31:0]      dest_s1, mask_s1;

	logic             v_s2, last_s2, hit_s2;
	logic [IDX_W-1:0] idx_s2;
	logic [5:0]       len_s2;

	logic             best_hit_q;
	logic [IDX_W-1:0] best_idx_q;
	logic [5:0]       best_len_q;

	logic             nxt_hit;
	logic [IDX_W-1:0] nxt_idx;
	logic [5:0]       nxt_len;

	logic             accept, wr_en, lk_en, ptr_last;

	assign busy     = (state_q != ST_IDLE);
	assign accept   = start && !busy;
	assign wr_en    = accept && (req.op == OP_WRITE) &&
	                  (32'(req.entry_index) < 32'(TABLE_DEPTH));
	assign lk_en    = accept && (req.op == OP_LOOKUP);
	assign ptr_last = (ptr_q == IDX_W'(VALID_DEPTH - 1));

	// Table storage
	always_ff @(posedge clk) begin
		if (wr_en) begin
			dest_mem[req.entry_index[IDX_W-1:0]] <= req.entry_dest;
			mask_mem[req.entry_index[IDX_W-1:0]] <= req.entry_mask;
		end
		if (state_q == ST_SCAN) begin
			dest_s1 <= dest_mem[ptr_q];
			mask_s1 <= mask_mem[ptr_q];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < VALID_DEPTH; i++) valid_q[i] <= 1'b0;
		end else if (wr_en) begin
			valid_q[req.entry_index[IDX_W-1:0]] <= req.entry_valid;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			ptr_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					ptr_q <= '0;
					if (lk_en) state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_last) state_q <= ST_DRAIN;
				end
				ST_DRAIN: begin
					if (v_s2 && last_s2) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (lk_en) addr_q <= req.lookup_addr;
		vbit_s1 <= valid_q[ptr_q];
		idx_s1  <= ptr_q;
		hit_s2  <= vbit_s1 && ((addr_q & mask_s1) == (dest_s1 & mask_s1));
		len_s2  <= lead_ones(mask_s1);
		idx_s2  <= idx_s1;
	end

	// Best-so-far update: strictly longer wins, so the lowest slot keeps ties
	always_comb begin
		nxt_hit = best_hit_q;
		nxt_idx = best_idx_q;
		nxt_len = best_len_q;
		if (v_s2 && hit_s2 && (!best_hit_q || (len_s2 > best_len_q))) begin
			nxt_hit = 1'b1;
			nxt_idx = idx_s2;
			nxt_len = len_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			last_s1    <= 1'b0;
			v_s2       <= 1'b0;
			last_s2    <= 1'b0;
			best_hit_q <= 1'b0;
			best_idx_q <= '0;
			best_len_q <= '0;
			done       <= 1'b0;
			rsp        <= '0;
		end else begin
			v_s1    <= (state_q == ST_SCAN);
			last_s1 <= (state_q == ST_SCAN) && ptr_last;
			v_s2    <= v_s1;
			last_s2 <= v_s1 && last_s1;
			done    <= 1'b0;
			if (lk_en) begin
				best_hit_q <= 1'b0;
				best_idx_q <= '0;
				best_len_q <= '0;
			end else begin
				best_hit_q <= nxt_hit;
				best_idx_q <= nxt_idx;
				best_len_q <= nxt_len;
			end
			if (v_s2 && last_s2) begin
				done                 <= 1'b1;
				rsp.found            <= nxt_hit;
				rsp.match_index      <= 4'(nxt_idx);
				rsp.match_prefix_len <= nxt_len;
			end
		end
	end

	`LPM_ASSERT_IMP(a_done_single, clk, arst_n, done, ##1 !done, "result strobe lasted two cycles")
	`LPM_ASSERT_IMP(a_done_after_busy, clk, arst_n, done, $past(busy) && !busy, "result without a lookup")
	`LPM_ASSERT_IMP(a_miss_zero, clk, arst_n, done && !rsp.found, (rsp.match_index == 4'd0) && (rsp.match_prefix_len == 6'd0), "miss carries nonzero fields")
	`LPM_ASSERT_IMP(a_len_range, clk, arst_n, done, rsp.match_prefix_len <= 6'd32, "prefix length out of range")

endmodule
`default_nettype wire
